// ----- rtl/mlosv_pkg.sv -----
package mlosv_pkg;

    // Store geometry and derived widths.
    localparam int MAX_B = 64;
    localparam int IDX_W = $clog2(MAX_B);
    localparam int NUM_W = IDX_W + 1;
    localparam int H_W = 30;
    localparam int DH_W = H_W + 1;
    localparam int PR_W = DH_W + IDX_W + 1;
    localparam int VIS_W = 6;
    localparam int VIS_MAX = 63;

    typedef struct packed {
        logic [H_W-1:0] height;
        logic           last;
    } t_in;

    typedef struct packed {
        logic [VIS_W-1:0] max_visible;
        logic             overflowed;
    } t_out;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_INIT,
        ST_STEP,
        ST_MAX,
        ST_OUT
    } t_state;

    // Control shared by every cell of the chain.
    typedef struct packed {
        logic             init;
        logic             step;
        logic             drain;
        logic [IDX_W-1:0] span;
    } t_cell_ctl;

    // True when there is no best slope yet, or when slope dh/d is strictly steeper than the best slope bdh/bdx so far.
    function automatic logic steeper(input logic signed [DH_W-1:0] dh,
                                     input logic signed [DH_W-1:0] bdh,
                                     input logic [IDX_W-1:0] bdx,
                                     input logic [IDX_W-1:0] d,
                                     input logic have_best);
        logic signed [PR_W-1:0] lhs;
        logic signed [PR_W-1:0] rhs;
        lhs = PR_W'(dh) * PR_W'($signed({1'b0, bdx}));
        rhs = PR_W'(bdh) * PR_W'($signed({1'b0, d}));
        return !have_best || (lhs > rhs);
    endfunction

endpackage

// ----- rtl/mlosv_cell.sv -----
module mlosv_cell (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  mlosv_pkg::t_cell_ctl              i_ctl,
    input  logic                              i_load,
    input  logic [mlosv_pkg::H_W-1:0]         i_height,
    input  logic                              i_valid,
    input  logic [mlosv_pkg::H_W-1:0]         i_rh,
    input  logic                              i_rv,
    input  logic [mlosv_pkg::H_W-1:0]         i_lh,
    input  logic                              i_lv,
    input  logic [mlosv_pkg::NUM_W-1:0]       i_cnt,
    output logic [mlosv_pkg::H_W-1:0]         o_rh,
    output logic                              o_rv,
    output logic [mlosv_pkg::H_W-1:0]         o_lh,
    output logic                              o_lv,
    output logic [mlosv_pkg::NUM_W-1:0]       o_cnt
);

    logic [mlosv_pkg::H_W-1:0]          r_h;
    logic                               r_own;
    logic [mlosv_pkg::H_W-1:0]          r_rh, r_lh;
    logic                               r_rv, r_lv;
    logic signed [mlosv_pkg::DH_W-1:0]  r_rbdh, r_lbdh;
    logic [mlosv_pkg::IDX_W-1:0]        r_rbdx, r_lbdx;
    logic                               r_rhb, r_lhb;
    logic [mlosv_pkg::NUM_W-1:0]        r_cnt;
    logic signed [mlosv_pkg::DH_W-1:0]  rdh, ldh;
    logic                               inc_r, inc_l;
    logic                               active;

    // Height differences to the buildings now passing on each line.
    assign rdh = $signed({1'b0, r_rh}) - $signed({1'b0, r_h});
    assign ldh = $signed({1'b0, r_lh}) - $signed({1'b0, r_h});
    assign active = i_ctl.step && (i_ctl.span != '0) && r_own;
    assign inc_r = active && r_rv &&
                   mlosv_pkg::steeper(rdh, r_rbdh, r_rbdx, i_ctl.span, r_rhb);
    assign inc_l = active && r_lv &&
                   mlosv_pkg::steeper(ldh, r_lbdh, r_lbdx, i_ctl.span, r_lhb);

    // Own height is written once while the profile loads.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_h <= i_height;
        end
    end

    // Init loads both lines; on step they carry heights outwards, one place per cycle; drain shifts the counts.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rv  <= 1'b0;
            r_lv  <= 1'b0;
            r_own <= 1'b0;
            r_rhb <= 1'b0;
            r_lhb <= 1'b0;
        end else if (i_ctl.init) begin
            r_rh   <= r_h;
            r_lh   <= r_h;
            r_rv   <= i_valid;
            r_lv   <= i_valid;
            r_own  <= i_valid;
            r_rhb  <= 1'b0;
            r_lhb  <= 1'b0;
            r_cnt  <= '0;
        end else if (i_ctl.step) begin
            r_rh <= i_rh;
            r_rv <= i_rv;
            r_lh <= i_lh;
            r_lv <= i_lv;
            if (inc_r) begin
                r_rhb  <= 1'b1;
                r_rbdh <= rdh;
                r_rbdx <= i_ctl.span;
            end
            if (inc_l) begin
                r_lhb  <= 1'b1;
                r_lbdh <= ldh;
                r_lbdx <= i_ctl.span;
            end
            r_cnt <= r_cnt + mlosv_pkg::NUM_W'(inc_r) + mlosv_pkg::NUM_W'(inc_l);
        end else if (i_ctl.drain) begin
            r_cnt <= i_cnt;
        end
    end

    assign o_rh  = r_rh;
    assign o_rv  = r_rv;
    assign o_lh  = r_lh;
    assign o_lv  = r_lv;
    assign o_cnt = r_cnt;

endmodule

// ----- rtl/max_line_of_sight_visibility_core.sv -----
// Heights are loaded one per transfer, one per cycle, while busy is low; the
// transfer marked last starts the evaluation. A chain of MAX_B cells, one per
// building, then passes heights outwards in both directions in the step state
// and drains the per-building counts through the chain in the max state, after
// which the result is on the ports in the out state and is taken at the next
// edge, strobed by o_done for one cycle. The receiver cannot stall the block;
// busy stays high until the result has gone.
module max_line_of_sight_visibility_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  mlosv_pkg::t_in    i_in,
    output logic              o_done,
    output mlosv_pkg::t_out   o_result
);

    mlosv_pkg::t_state                 r_state, n_state;
    logic [mlosv_pkg::NUM_W-1:0]       r_num, n_num;
    logic                              r_ovf, n_ovf;
    logic [mlosv_pkg::IDX_W-1:0]       r_dist, n_dist;
    logic [mlosv_pkg::NUM_W-1:0]       r_max, n_max;
    mlosv_pkg::t_cell_ctl              ctl;
    logic                              acc, room;

    logic [mlosv_pkg::H_W-1:0]   rh  [mlosv_pkg::MAX_B];
    logic                        rv  [mlosv_pkg::MAX_B];
    logic [mlosv_pkg::H_W-1:0]   lh  [mlosv_pkg::MAX_B];
    logic                        lv  [mlosv_pkg::MAX_B];
    logic [mlosv_pkg::NUM_W-1:0] cnt [mlosv_pkg::MAX_B];

    assign acc  = start && !busy;
    assign room = r_num < mlosv_pkg::NUM_W'(mlosv_pkg::MAX_B);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mlosv_pkg::ST_LOAD: if (acc && i_in.last) n_state = mlosv_pkg::ST_INIT;
            mlosv_pkg::ST_INIT: n_state = mlosv_pkg::ST_STEP;
            mlosv_pkg::ST_STEP: if (&r_dist) n_state = mlosv_pkg::ST_MAX;
            mlosv_pkg::ST_MAX:  if (&r_dist) n_state = mlosv_pkg::ST_OUT;
            mlosv_pkg::ST_OUT:  n_state = mlosv_pkg::ST_LOAD;
            default:            n_state = mlosv_pkg::ST_LOAD;
        endcase
    end

    // Outputs and counters.
    always_comb begin
        n_num     = r_num;
        n_ovf     = r_ovf;
        n_dist    = r_dist;
        n_max     = r_max;
        ctl.init  = 1'b0;
        ctl.step  = 1'b0;
        ctl.drain = 1'b0;
        ctl.span  = r_dist;
        busy      = 1'b1;
        o_done    = 1'b0;
        unique case (r_state)
            mlosv_pkg::ST_LOAD: begin
                busy = 1'b0;
                if (acc) begin
                    if (room) begin
                        n_num = r_num + mlosv_pkg::NUM_W'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                end
            end
            mlosv_pkg::ST_INIT: begin
                ctl.init = 1'b1;
                n_dist   = '0;
                n_max    = '0;
            end
            mlosv_pkg::ST_STEP: begin
                ctl.step = 1'b1;
                n_dist   = r_dist + mlosv_pkg::IDX_W'(1);
            end
            mlosv_pkg::ST_MAX: begin
                ctl.drain = 1'b1;
                n_dist    = r_dist + mlosv_pkg::IDX_W'(1);
                if (cnt[0] > r_max) n_max = cnt[0];
            end
            mlosv_pkg::ST_OUT: begin
                o_done = 1'b1;
                n_num  = '0;
                n_ovf  = 1'b0;
            end
            default: ;
        endcase
    end

    // Result fields, saturated.
    always_comb begin
        o_result.overflowed = r_ovf;
        if (r_max > mlosv_pkg::NUM_W'(mlosv_pkg::VIS_MAX)) begin
            o_result.max_visible = mlosv_pkg::VIS_W'(mlosv_pkg::VIS_MAX);
        end else begin
            o_result.max_visible = r_max[mlosv_pkg::VIS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mlosv_pkg::ST_LOAD;
            r_num   <= '0;
            r_ovf   <= 1'b0;
            r_dist  <= '0;
            r_max   <= '0;
        end else begin
            r_state <= n_state;
            r_num   <= n_num;
            r_ovf   <= n_ovf;
            r_dist  <= n_dist;
            r_max   <= n_max;
        end
    end

    // The chain of cells, one per building slot.
    for (genvar g = 0; g < mlosv_pkg::MAX_B; g++) begin : g_cell
        logic [mlosv_pkg::H_W-1:0]   in_rh, in_lh;
        logic                        in_rv, in_lv;
        logic [mlosv_pkg::NUM_W-1:0] in_cnt;
        logic                        load;

        if (g == mlosv_pkg::MAX_B - 1) begin : g_top
            assign in_rh  = '0;
            assign in_rv  = 1'b0;
            assign in_cnt = '0;
        end else begin : g_mid
            assign in_rh  = rh[g+1];
            assign in_rv  = rv[g+1];
            assign in_cnt = cnt[g+1];
        end
        if (g == 0) begin : g_bot
            assign in_lh = '0;
            assign in_lv = 1'b0;
        end else begin : g_low
            assign in_lh = lh[g-1];
            assign in_lv = lv[g-1];
        end

        assign load = acc && room &&
                      (r_num[mlosv_pkg::IDX_W-1:0] == mlosv_pkg::IDX_W'(g));

        mlosv_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (ctl),
            .i_load   (load),
            .i_height (i_in.height),
            .i_valid  (r_num > mlosv_pkg::NUM_W'(g)),
            .i_rh     (in_rh),
            .i_rv     (in_rv),
            .i_lh     (in_lh),
            .i_lv     (in_lv),
            .i_cnt    (in_cnt),
            .o_rh     (rh[g]),
            .o_rv     (rv[g]),
            .o_lh     (lh[g]),
            .o_lv     (lv[g]),
            .o_cnt    (cnt[g])
        );
    end

endmodule

// ----- sim/max_line_of_sight_visibility_core_test.sv -----
module max_line_of_sight_visibility_core_test;

    // Expected results of the profile visibility computation.
    class visibility_scoreboard;
        logic [mlosv_pkg::H_W-1:0] profile[$];
        bit                        dropped;
        mlosv_pkg::t_out           pending[$];
        int                        errors;

        // Counts the buildings seen from building c in one direction.
        function int count_side(int c, int dir);
            int     seen;
            int     j;
            longint hc;
            longint dh;
            longint dx;
            longint bdh;
            longint bdx;
            bit     have;
            seen = 0;
            have = 0;
            bdh = 0;
            bdx = 1;
            hc = longint'(profile[c]);
            j = c + dir;
            while (j >= 0 && j < profile.size()) begin
                dh = longint'(profile[j]) - hc;
                dx = (j - c) * dir;
                if (!have || dh * bdx > bdh * dx) begin
                    seen++;
                    have = 1;
                    bdh = dh;
                    bdx = dx;
                end
                j += dir;
            end
            return seen;
        endfunction

        // Notes an accepted input transfer.
        function void note_load(mlosv_pkg::t_in item);
            int              best;
            int              v;
            mlosv_pkg::t_out r;
            if (profile.size() < mlosv_pkg::MAX_B)
                profile.push_back(item.height);
            else
                dropped = 1;
            if (item.last) begin
                best = 0;
                for (int c = 0; c < profile.size(); c++) begin
                    v = count_side(c, 1) + count_side(c, -1);
                    if (v > best)
                        best = v;
                end
                if (best > mlosv_pkg::VIS_MAX)
                    best = mlosv_pkg::VIS_MAX;
                r.max_visible = best[mlosv_pkg::VIS_W-1:0];
                r.overflowed = dropped;
                pending.push_back(r);
                profile.delete();
                dropped = 0;
            end
        endfunction

        // Checks one result against the oldest expectation.
        function void check_result(mlosv_pkg::t_out got);
            mlosv_pkg::t_out exp_r;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %p", $time, got);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (got.max_visible !== exp_r.max_visible) begin
                $display("%0t: max_visible expected %0d actual %0d",
                         $time, exp_r.max_visible, got.max_visible);
                errors++;
            end
            if (got.overflowed !== exp_r.overflowed) begin
                $display("%0t: overflowed expected %0d actual %0d",
                         $time, exp_r.overflowed, got.overflowed);
                errors++;
            end
        endfunction
    endclass

    logic            i_clk = 0;
    logic            i_rst_n = 0;
    logic            start = 0;
    logic            busy;
    mlosv_pkg::t_in  i_in = '0;
    logic            o_done;
    mlosv_pkg::t_out o_result;

    visibility_scoreboard board = new();
    int   idle_pct = 0;
    int   cycles = 0;
    int   sent = 0;

    max_line_of_sight_visibility_core u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_in     (i_in),
        .o_done   (o_done),
        .o_result (o_result)
    );

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    // Sample transfers and results at the rising edge; enforce the cycle limit.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n) begin
            if (start && !busy)
                board.note_load(i_in);
            if (o_done)
                board.check_result(o_result);
        end
        if (cycles > 2000000) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Drives one building and waits for its transfer, idling at random before it.
    // Start is left high afterwards; the next call lowers it only when it idles, or the caller lowers it.
    task automatic send_building(logic [mlosv_pkg::H_W-1:0] h, logic lst);
        while ($urandom_range(99) < idle_pct) begin
            start <= 0;
            @(negedge i_clk);
        end
        start <= 1;
        i_in.height <= h;
        i_in.last <= lst;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
        sent++;
    endtask

    // Heights with a mixture of extremes, small values and full random words.
    function automatic logic [mlosv_pkg::H_W-1:0] rand_height();
        case ($urandom_range(4))
            0: return mlosv_pkg::H_W'($urandom_range(7));
            1: return {mlosv_pkg::H_W{1'b1}} - mlosv_pkg::H_W'($urandom_range(3));
            2: return mlosv_pkg::H_W'($urandom_range(1000));
            default: return mlosv_pkg::H_W'($urandom());
        endcase
    endfunction

    task automatic send_profile(int n);
        for (int i = 0; i < n; i++)
            send_building(rand_height(), i == n - 1);
    endtask

    initial begin
        int n;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1;
        // Directed: single low and high, flat, peak, rising, and a full store with overflow.
        send_building('0, 1'b1);
        send_building({mlosv_pkg::H_W{1'b1}}, 1'b1);
        send_building(mlosv_pkg::H_W'(5), 1'b0);
        send_building(mlosv_pkg::H_W'(5), 1'b0);
        send_building(mlosv_pkg::H_W'(5), 1'b1);
        send_building('0, 1'b0);
        send_building({mlosv_pkg::H_W{1'b1}}, 1'b0);
        send_building('0, 1'b1);
        for (int i = 0; i < 4; i++)
            send_building(mlosv_pkg::H_W'(i * 3), i == 3);
        for (int i = 0; i < mlosv_pkg::MAX_B + 2; i++)
            send_building(rand_height(), i == mlosv_pkg::MAX_B + 1);
        // Random profiles in idling phases.
        for (int ph = 0; ph < 4; ph++) begin
            idle_pct = (ph == 1) ? 84 : (ph == 3) ? 8 : 0;
            while (sent < 80 + (ph + 1) * 345) begin
                case ($urandom_range(9))
                    0: n = mlosv_pkg::MAX_B + $urandom_range(1, 4);
                    1: n = mlosv_pkg::MAX_B;
                    2: n = $urandom_range(1, 2);
                    default: n = $urandom_range(3, 20);
                endcase
                send_profile(n);
            end
        end
        start <= 0;
        while (board.pending.size() != 0)
            @(posedge i_clk);
        repeat (2 * mlosv_pkg::MAX_B + 10) @(posedge i_clk);
        if (board.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

// ----- sim.f -----
rtl/mlosv_pkg.sv
rtl/mlosv_cell.sv
rtl/max_line_of_sight_visibility_core.sv
sim/max_line_of_sight_visibility_core_test.sv
